FILE: hw/rtl/lsnp_pkg.sv
// ----------------------------------------------------------------------------
// lsnp_pkg
// Shared types and constants for the lidar scan node parser.
// ----------------------------------------------------------------------------
package lsnp_pkg;

	// Field widths.
	localparam int unsigned ANGLE_W = 9;
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned QUAL_W  = 6;
	localparam int unsigned BYTE_W  = 8;

	// Distance table depth in whole degrees.
	localparam int unsigned TABLE_DEPTH = 360;
	localparam logic [ANGLE_W-1:0] LAST_ENTRY = ANGLE_W'(TABLE_DEPTH - 1);
	localparam logic [ANGLE_W-1:0] DEPTH_9B = ANGLE_W'(TABLE_DEPTH);

	// Item kinds on the input and result channels.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// A decoded node as it leaves the window logic.
	typedef struct packed {
		logic               hit;
		logic [ANGLE_W-1:0] angle;
		logic [DIST_W-1:0]  distance;
		logic [QUAL_W-1:0]  quality;
	} lsnp_node_t;

	// Write request into the distance table.
	typedef struct packed {
		logic               en;
		logic [ANGLE_W-1:0] addr;
		logic [DIST_W-1:0]  data;
	} lsnp_tbl_wr_t;

endpackage

FILE: hw/rtl/lsnp_window.sv
// ----------------------------------------------------------------------------
// lsnp_window
// Five-byte node window with sync test and node decode.
// ----------------------------------------------------------------------------
module lsnp_window import lsnp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_en,
	input  logic [BYTE_W-1:0] byte_in,
	output lsnp_node_t        node
);

	logic [BYTE_W-1:0] win_q [0:3];
	logic [2:0]        count_q;
	logic              full;
	logic              sync_ok;
	logic [14:0]       raw_angle;
	logic [15:0]       rounded;
	logic [9:0]        whole_deg;
	logic [9:0]        wrapped;

	// The fifth byte completes the window; bytes 0 to 3 are already stored.
	assign full    = (count_q == 3'd4);
	assign sync_ok = win_q[1][0] && (win_q[0][0] != win_q[0][1]);

	// Angle in 1/64 degree, rounded half up to whole degrees and wrapped once.
	assign raw_angle = {win_q[2], win_q[1][7:1]};
	assign rounded   = {1'b0, raw_angle} + 16'd32;
	assign whole_deg = rounded[15:6];
	assign wrapped   = (whole_deg >= 10'(TABLE_DEPTH)) ?
		(whole_deg - 10'(TABLE_DEPTH)) : whole_deg;

	always_comb begin
		node.hit      = byte_en && full && sync_ok;
		node.angle    = wrapped[ANGLE_W-1:0];
		node.distance = {byte_in, win_q[3]};
		node.quality  = win_q[0][7:2];
	end

	// Fill count: advances per byte, clears on a good node, stays at four on a resync.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
		end else if (byte_en) begin
			if (!full) begin
				count_q <= count_q + 3'd1;
			end else if (sync_ok) begin
				count_q <= 3'd0;
			end
		end
	end

	// Window bytes: fill in place, or drop the oldest byte when the test fails.
	always_ff @(posedge clk) begin
		if (byte_en) begin
			if (!full) begin
				win_q[count_q[1:0]] <= byte_in;
			end else if (!sync_ok) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= win_q[3];
				win_q[3] <= byte_in;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("window count beyond four");
	a_hit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		node.hit |=> count_q == 3'd0)
		else $error("window not emptied after a node");
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		node.hit |-> node.angle < DEPTH_9B)
		else $error("node angle not wrapped");
`endif

endmodule

FILE: hw/rtl/lsnp_dist_table.sv
// ----------------------------------------------------------------------------
// lsnp_dist_table
// 360-entry distance memory with a clearing pass after reset.
// ----------------------------------------------------------------------------
module lsnp_dist_table import lsnp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lsnp_tbl_wr_t       wr,
	input  logic               rd_en,
	input  logic [ANGLE_W-1:0] rd_addr,
	output logic [DIST_W-1:0]  rd_data,
	output logic               clearing
);

	logic [DIST_W-1:0]  mem [0:TABLE_DEPTH-1];
	logic [DIST_W-1:0]  rd_data_q;
	logic [ANGLE_W-1:0] clr_addr_q;
	logic               clr_busy_q;

	assign clearing = clr_busy_q;
	assign rd_data  = rd_data_q;

	// Clearing pass: one entry per cycle from the bottom up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == LAST_ENTRY) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + ANGLE_W'(1);
		end
	end

	// Single write port shared by the clearing pass and node updates.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

`ifndef SYNTHESIS
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !wr.en && !rd_en)
		else $error("table access during clearing pass");
`endif

endmodule

FILE: hw/rtl/lidar_scan_node_parser.sv
// ----------------------------------------------------------------------------
// lidar_scan_node_parser
// Lidar byte stream parser for five-byte measurement nodes with distance table.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, a scanner byte or a table read,
// while the result side keeps up and no clearing pass runs. Every item is held
// in the input register and then, if it gives a result, moves to the result
// register once that is free, so a new item can follow every cycle while the
// result side keeps up. Bytes are parsed only while scan_enable is set; a
// good node updates the distance table and is emitted, a read returns the
// entry stored at read_angle (zero for an index of 360 or more). After reset
// the table is swept to zero, during which in_ready stays low; configuration
// writes are taken at any time.
module lidar_scan_node_parser import lsnp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic [ANGLE_W-1:0] read_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [ANGLE_W-1:0] angle_deg,
	output logic [DIST_W-1:0]  distance_qmm,
	output logic [QUAL_W-1:0]  quality
);

	logic               scan_enable_q;
	logic               valid_s1;
	logic               kind_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic [ANGLE_W-1:0] angle_s1;
	logic               valid_s2;
	logic               kind_s2;
	logic               oor_s2;
	logic [ANGLE_W-1:0] angle_s2;
	logic [DIST_W-1:0]  dist_s2;
	logic [QUAL_W-1:0]  qual_s2;
	logic               s2_free;
	logic               s1_adv;
	logic               s1_result;
	logic               byte_en;
	logic               rd_en;
	logic               clearing;
	logic [DIST_W-1:0]  rd_data;
	lsnp_node_t         node;
	lsnp_tbl_wr_t       tbl_wr;

	// Scan enable register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			scan_enable_q <= cfg_wr_data;
		end
	end

	// Flow control between the two stages.
	assign s2_free   = !valid_s2 || out_ready;
	assign s1_adv    = valid_s1 && s2_free;
	assign in_ready  = !clearing && (!valid_s1 || s2_free);
	assign byte_en   = s1_adv && (kind_s1 == KIND_BYTE) && scan_enable_q;
	assign rd_en     = s1_adv && (kind_s1 == KIND_READ) && (angle_s1 < DEPTH_9B);
	assign s1_result = (kind_s1 == KIND_READ) || node.hit;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1  <= kind;
			byte_s1  <= data_byte;
			angle_s1 <= read_angle;
		end
	end

	lsnp_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (byte_en),
		.byte_in (byte_s1),
		.node    (node)
	);

	// A good node is written at its rounded angle.
	always_comb begin
		tbl_wr.en   = node.hit;
		tbl_wr.addr = node.angle;
		tbl_wr.data = node.distance;
	end

	lsnp_dist_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_en    (rd_en),
		.rd_addr  (angle_s1),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	// Result register; read data arrives from the table's own output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && s1_result;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_result) begin
			kind_s2 <= kind_s1;
			oor_s2  <= (angle_s1 >= DEPTH_9B);
			if (kind_s1 == KIND_READ) begin
				angle_s2 <= angle_s1;
				dist_s2  <= '0;
				qual_s2  <= '0;
			end else begin
				angle_s2 <= node.angle;
				dist_s2  <= node.distance;
				qual_s2  <= node.quality;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign result_kind  = kind_s2;
	assign angle_deg    = angle_s2;
	assign quality      = qual_s2;
	assign distance_qmm = (kind_s2 == KIND_READ) ? (oor_s2 ? '0 : rd_data) : dist_s2;

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready && !valid_s1)
		else $error("item taken during clearing pass");
`endif

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar scan node parser.
// A short directed table covers reads of the cleared table, the angle wrap,
// paused scanning and resync after bad windows. Random phases follow, mostly
// well-formed nodes with random content mixed with reads, broken nodes and
// noise bytes; scan_enable changes between phases. Results are checked field
// by field against its directed row or a model of window, decode and table.
// ----------------------------------------------------------------------------
module tb_top;
	import lsnp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int PHASE_ITEMS  = 144;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 200;
	// scan_enable per random phase, phase 0 in bit 0.
	localparam logic [7:0] SCAN_PLAN = 8'b1110_1101;

	typedef enum logic [1:0] {ROW_ITEM, ROW_SCAN_ON, ROW_SCAN_OFF} row_op_e;

	typedef struct packed {
		logic               kind;
		logic [BYTE_W-1:0]  rx_byte;
		logic [ANGLE_W-1:0] angle;
	} scan_item_t;

	typedef struct packed {
		logic               rkind;
		logic [ANGLE_W-1:0] angle;
		logic [DIST_W-1:0]  distance;
		logic [QUAL_W-1:0]  qual;
	} node_report_t;

	typedef struct packed {
		row_op_e      op;
		scan_item_t   it;
		logic         typed;
		node_report_t want;
	} stim_row_t;

	localparam int N_DIRECTED = 31;
	localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
		// Straight after reset the table reads as zero, in and out of range.
		'{ROW_ITEM, '{KIND_READ, 8'h5A, 9'd0},   1'b1, '{KIND_READ, 9'd0,   16'd0, 6'd0}},
		'{ROW_ITEM, '{KIND_READ, 8'hA5, 9'd359}, 1'b1, '{KIND_READ, 9'd359, 16'd0, 6'd0}},
		'{ROW_ITEM, '{KIND_READ, 8'h00, 9'd511}, 1'b1, '{KIND_READ, 9'd511, 16'd0, 6'd0}},
		// A byte is ignored while scanning is off.
		'{ROW_ITEM, '{KIND_BYTE, 8'hFF, 9'd0}, 1'b0, '0},
		'{ROW_SCAN_ON, '0, 1'b0, '0},
		// Largest raw angle rounds to 512 and wraps to 152; widest fields.
		'{ROW_ITEM, '{KIND_BYTE, 8'hFD, 9'h1FF}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'hFF, 9'h000}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'hFF, 9'h1FF}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'hFF, 9'h000}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'hFF, 9'h1FF}, 1'b1, '{KIND_BYTE, 9'd152, 16'hFFFF, 6'd63}},
		// Rounds up to exactly 360, which wraps to zero; paused mid-node.
		'{ROW_ITEM, '{KIND_BYTE, 8'h02, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'hC1, 9'd0}, 1'b0, '0},
		'{ROW_SCAN_OFF, '0, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'hAA, 9'd0}, 1'b0, '0},
		'{ROW_SCAN_ON, '0, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'hB3, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h34, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h12, 9'd0}, 1'b1, '{KIND_BYTE, 9'd0, 16'h1234, 6'd0}},
		// Both nodes must now sit in the table.
		'{ROW_ITEM, '{KIND_READ, 8'h00, 9'd0},   1'b1, '{KIND_READ, 9'd0,   16'h1234, 6'd0}},
		'{ROW_ITEM, '{KIND_READ, 8'hFF, 9'd152}, 1'b1, '{KIND_READ, 9'd152, 16'hFFFF, 6'd0}},
		// Resync: both flags, check bit clear, neither flag, then a node lines up.
		'{ROW_ITEM, '{KIND_BYTE, 8'h03, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h01, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h00, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h00, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h00, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h00, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h01, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h05, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h41, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h20, 9'd0}, 1'b0, '0},
		'{ROW_ITEM, '{KIND_BYTE, 8'h10, 9'd0}, 1'b0, '0}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic               cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic               kind;
	logic [BYTE_W-1:0]  data_byte;
	logic [ANGLE_W-1:0] read_angle;
	logic               out_valid;
	logic               out_ready;
	logic               result_kind;
	logic [ANGLE_W-1:0] angle_deg;
	logic [DIST_W-1:0]  distance_qmm;
	logic [QUAL_W-1:0]  quality;

	// Model state: scan enable, byte window and distance table.
	logic              scan_on;
	logic [BYTE_W-1:0] byte_win [0:4];
	int                win_fill;
	logic [DIST_W-1:0] range_mem [0:TABLE_DEPTH-1];

	node_report_t pending_reports [$];
	int           items_sent;
	int           results_seen;
	int           mismatches;
	int           cycles;

	lidar_scan_node_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.data_byte    (data_byte),
		.read_angle   (read_angle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.angle_deg    (angle_deg),
		.distance_qmm (distance_qmm),
		.quality      (quality)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// Runaway guard.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic log_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Steps the model by one accepted item; returns 1 when a result is due.
	function automatic bit predict_node(input scan_item_t it, output node_report_t r);
		logic [14:0] raw;
		logic [15:0] deg;
		r = '0;
		if (it.kind == KIND_READ) begin
			r.rkind    = KIND_READ;
			r.angle    = it.angle;
			r.distance = (it.angle < TABLE_DEPTH) ? range_mem[it.angle] : '0;
			return 1'b1;
		end
		if (!scan_on)
			return 1'b0;
		byte_win[win_fill] = it.rx_byte;
		win_fill++;
		if (win_fill < 5)
			return 1'b0;
		// Bad window: drop the oldest byte and keep the other four.
		if (!(byte_win[1][0] && (byte_win[0][0] != byte_win[0][1]))) begin
			for (int i = 0; i < 4; i++)
				byte_win[i] = byte_win[i+1];
			win_fill = 4;
			return 1'b0;
		end
		raw = {byte_win[2], byte_win[1][7:1]};
		deg = (16'(raw) + 16'd32) >> 6;
		if (deg >= TABLE_DEPTH)
			deg -= 16'(TABLE_DEPTH);
		r.rkind    = KIND_BYTE;
		r.angle    = deg[ANGLE_W-1:0];
		r.distance = {byte_win[4], byte_win[3]};
		r.qual     = byte_win[0][7:2];
		range_mem[r.angle] = r.distance;
		win_fill = 0;
		return 1'b1;
	endfunction

	// Offers one item, waits for its transaction and records what it should give.
	task automatic send_item(input scan_item_t it, input bit typed, input node_report_t want);
		node_report_t r;
		bit           has;
		while (!(items_sent >= 500 && items_sent < 700) && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= it.kind;
		data_byte  <= it.rx_byte;
		read_angle <= it.angle;
		do
			@(posedge clk);
		while (!in_ready);
		has = predict_node(it, r);
		if (has)
			pending_reports.push_back(typed ? want : r);
		items_sent++;
		@(negedge clk);
	endtask

	// Writes scan_enable once the block has drained.
	task automatic set_scan(input logic on);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= on;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		scan_on = on;
	endtask

	// Result side: random stalls, a calm stretch and one long hold-off.
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held      = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (results_seen >= 150 && results_seen < 300) ||
					($urandom_range(99) >= 10);
			end
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		node_report_t got;
		node_report_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{result_kind, angle_deg, distance_qmm, quality};
			if (pending_reports.size() == 0) begin
				log_mismatch($sformatf("unexpected result kind %0d angle %0d dist %0d",
					got.rkind, got.angle, got.distance));
			end else begin
				want = pending_reports.pop_front();
				if (got.rkind != want.rkind)
					log_mismatch($sformatf("result_kind got %0d want %0d", got.rkind, want.rkind));
				if (got.angle != want.angle)
					log_mismatch($sformatf("angle_deg got %0d want %0d", got.angle, want.angle));
				if (got.distance != want.distance)
					log_mismatch($sformatf("distance_qmm got %0d want %0d",
						got.distance, want.distance));
				if (got.qual != want.qual)
					log_mismatch($sformatf("quality got %0d want %0d", got.qual, want.qual));
			end
			results_seen++;
		end
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin
		scan_item_t    it;
		logic [14:0]   raw;
		logic [7:0]    nb [0:4];
		int            n_bytes;
		int            phase_end;
		int unsigned   pick;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_BYTE;
		data_byte    = '0;
		read_angle   = '0;
		scan_on      = 1'b0;
		win_fill     = 0;
		items_sent   = 0;
		results_seen = 0;
		mismatches   = 0;
		cycles       = 0;
		foreach (range_mem[i])
			range_mem[i] = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			case (DIRECTED[i].op)
				ROW_SCAN_ON:  set_scan(1'b1);
				ROW_SCAN_OFF: set_scan(1'b0);
				default:      send_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].want);
			endcase
		end

		for (int p = 0; p < 8; p++) begin
			set_scan(SCAN_PLAN[p]);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					// Well-formed node with random content; some are broken or cut short.
					if ($urandom_range(3) == 0)
						raw = 15'($urandom_range(23071, 22944));
					else
						raw = 15'($urandom);
					nb[0] = {6'($urandom), ($urandom_range(1) != 0) ? 2'b01 : 2'b10};
					nb[1] = {raw[6:0], 1'b1};
					nb[2] = raw[14:7];
					nb[3] = 8'($urandom);
					nb[4] = 8'($urandom);
					n_bytes = 5;
					if (pick >= 60) begin
						case ($urandom_range(3))
							0:       nb[0][1:0] = 2'b11;
							1:       nb[0][1:0] = 2'b00;
							2:       nb[1][0] = 1'b0;
							default: n_bytes = $urandom_range(4, 1);
						endcase
					end
					for (int j = 0; j < n_bytes; j++) begin
						it = '{KIND_BYTE, nb[j], 9'($urandom)};
						send_item(it, 1'b0, '0);
					end
				end else if (pick < 85) begin
					it.kind    = KIND_READ;
					it.rx_byte = 8'($urandom);
					if ($urandom_range(9) == 0)
						it.angle = 9'($urandom_range(511, 360));
					else
						it.angle = 9'($urandom_range(359, 0));
					send_item(it, 1'b0, '0);
				end else begin
					it = '{KIND_BYTE, 8'($urandom), 9'($urandom)};
					send_item(it, 1'b0, '0);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (4 * DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
